// ----- hdl/cubic_bezier_point_eval_defines.svh -----
// Assertion macros shared by the cubic Bezier point evaluator.
// Taken in by `include from the modules that carry checks; no dependencies.
`ifndef CUBIC_BEZIER_POINT_EVAL_DEFINES_SVH
`define CUBIC_BEZIER_POINT_EVAL_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Clocked check, switched off while reset is held
`define BZP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bezier check failed");
// Clocked check that also runs through reset
`define BZP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("bezier check failed");
`else
`define BZP_ASSERT(label, clk, rst_n, prop)
`define BZP_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- hdl/bzp_pkg.sv -----
// Shared constants, widths and types for the cubic Bezier point evaluator.
// No dependencies.
`timescale 1ns / 1ps

package bzp_pkg;

    // Field widths
    localparam int COORD_WIDTH = 16;
    localparam int T_WIDTH     = 16;
    localparam int NUM_POINTS  = 4;
    localparam int NUM_COORDS  = 3;
    localparam int CFG_WIDTH   = NUM_COORDS * COORD_WIDTH;
    localparam int CFG_IDX_W   = 8;
    localparam int PT_IDX_W    = $clog2(NUM_POINTS);

    // Pipeline depth, input to output register
    localparam int NUM_STAGES  = 6;

    // Polynomial coefficient widths (3*d, 3*second diff, third diff)
    localparam int C1_W = COORD_WIDTH + 3;
    localparam int C2_W = COORD_WIDTH + 4;
    localparam int C3_W = COORD_WIDTH + 4;

    // t as a signed operand with a zero top bit
    localparam int A_W = T_WIDTH + 1;

    // Horner accumulators and their split points for the partial products
    localparam int ACC1_W = C3_W + A_W;
    localparam int LO1_W  = ACC1_W / 2;
    localparam int HI1_W  = ACC1_W - LO1_W;
    localparam int ACC2_W = ACC1_W + A_W;
    localparam int LO2_W  = ACC2_W / 2;
    localparam int HI2_W  = ACC2_W - LO2_W;
    localparam int ACC3_W = ACC2_W + A_W;

    // Binary point of the final sum and the rounding half
    localparam int RND_POS = 3 * T_WIDTH;
    localparam logic [ACC3_W-1:0] RND_HALF = ACC3_W'(1) << (RND_POS - 1);

    // Per-coordinate power-basis coefficients
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] p0;
        logic signed [C1_W-1:0]        c1;
        logic signed [C2_W-1:0]        c2;
        logic signed [C3_W-1:0]        c3;
    } t_coef;

    typedef t_coef [NUM_COORDS-1:0] t_coef_vec;

    // Stage advance enables handed to each lane
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } t_pipe_ctl;

endpackage

// ----- hdl/cubic_bezier_point_eval.sv -----
// Cubic Bezier point evaluator: one t in, one rounded (x, y, z) point out.
// Throughput: one point per cycle while the output is not stalled; six stages:
//   capture, first multiply by t, then a product and a sum stage for each of
//   the other two multiplies.
// Reset (synchronous, active low) empties the pipeline, control points to zero.
// Depends on bzp_pkg, bzp_coef, bzp_lane and the assertion macro header.
`timescale 1ns / 1ps
`include "cubic_bezier_point_eval_defines.svh"

module cubic_bezier_point_eval
    import bzp_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_WIDTH-1:0]          i_cfg_data,
    // parameter beats in
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [T_WIDTH-1:0]            i_t_frac,
    // point beats out
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0] o_x_out,
    output logic signed [COORD_WIDTH-1:0] o_y_out,
    output logic signed [COORD_WIDTH-1:0] o_z_out
);

    logic [NUM_STAGES-1:0] r_vld;
    t_pipe_ctl             ctl;
    t_coef_vec             coef;
    logic signed [COORD_WIDTH-1:0] res [NUM_COORDS];

    // Configuration always taken
    assign o_cfg_ready = 1'b1;

    bzp_coef u_coef (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_coef     (coef)
    );

    // A stage advances when it is empty or the one after it advances
    always_comb begin
        ctl.en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            ctl.en[k] = !r_vld[k] || ctl.en[k+1];
        end
    end

    assign o_stall = !ctl.en[0];
    assign o_valid = r_vld[NUM_STAGES-1];

    // Valid bits travel alongside the lane data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ctl.en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (ctl.en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // One datapath per coordinate
    for (genvar k = 0; k < NUM_COORDS; k++) begin : g_lane
        bzp_lane u_lane (
            .i_clk  (i_clk),
            .i_ctl  (ctl),
            .i_t    (i_t_frac),
            .i_coef (coef[k]),
            .o_res  (res[k])
        );
    end

    assign o_x_out = res[0];
    assign o_y_out = res[1];
    assign o_z_out = res[2];

    // Input is held off only when every stage holds a beat
    `BZP_ASSERT(a_stall_full, i_clk, i_rst_n, o_stall |-> (&r_vld))
    // A finished beat moves into the output register when it is free
    `BZP_ASSERT(a_last_moves, i_clk, i_rst_n,
        (r_vld[NUM_STAGES-2] && !(r_vld[NUM_STAGES-1] && i_stall)) |=> r_vld[NUM_STAGES-1])
    // Reset leaves the pipeline empty
    `BZP_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> (r_vld == '0))

endmodule

// ----- hdl/bzp_coef.sv -----
// Control point registers and the power-basis coefficients derived from them.
// Depends on bzp_pkg.
`timescale 1ns / 1ps

module bzp_coef
    import bzp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [CFG_IDX_W-1:0] i_wr_index,
    input  logic [CFG_WIDTH-1:0] i_wr_data,
    output t_coef_vec            o_coef
);

    logic [CFG_WIDTH-1:0] r_point [NUM_POINTS];

    // Register writes; indexes past the last point are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_POINTS; i++) begin
                r_point[i] <= '0;
            end
        end else if (i_wr_en && (i_wr_index < CFG_IDX_W'(NUM_POINTS))) begin
            r_point[i_wr_index[PT_IDX_W-1:0]] <= i_wr_data;
        end
    end

    // Bernstein to power basis, one set per coordinate
    for (genvar k = 0; k < NUM_COORDS; k++) begin : g_coord
        logic signed [COORD_WIDTH-1:0] p0, p1, p2, p3;
        logic signed [C1_W-1:0]        d1;
        logic signed [C2_W-1:0]        d2;
        logic signed [C3_W-1:0]        d3;

        assign p0 = r_point[0][k*COORD_WIDTH +: COORD_WIDTH];
        assign p1 = r_point[1][k*COORD_WIDTH +: COORD_WIDTH];
        assign p2 = r_point[2][k*COORD_WIDTH +: COORD_WIDTH];
        assign p3 = r_point[3][k*COORD_WIDTH +: COORD_WIDTH];

        // d1 = p1 - p0, d2 = p0 - 2 p1 + p2, d3 = p1 - p2
        assign d1 = C1_W'(p1) - C1_W'(p0);
        assign d2 = C2_W'(p0) - (C2_W'(p1) <<< 1) + C2_W'(p2);
        assign d3 = C3_W'(p1) - C3_W'(p2);

        assign o_coef[k].p0 = p0;
        assign o_coef[k].c1 = (d1 <<< 1) + d1;
        assign o_coef[k].c2 = (d2 <<< 1) + d2;
        assign o_coef[k].c3 = C3_W'(p3) - C3_W'(p0) + (d3 <<< 1) + d3;
    end

endmodule

// ----- hdl/bzp_lane.sv -----
// One coordinate's Horner datapath: three multiplies by t, the last two cut into
// partial products and summed a stage later. Depends on bzp_pkg.
`timescale 1ns / 1ps

module bzp_lane
    import bzp_pkg::*;
(
    input  logic                          i_clk,
    input  t_pipe_ctl                     i_ctl,
    input  logic [T_WIDTH-1:0]            i_t,
    input  t_coef                         i_coef,
    output logic signed [COORD_WIDTH-1:0] o_res
);

    // Stage 1: capture t and coefficients
    logic [T_WIDTH-1:0] r_a1;
    t_coef              r_cf1;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_a1  <= i_t;
            r_cf1 <= i_coef;
        end
    end

    // Stage 2: acc1 = c3*t + c2 << T
    logic signed [A_W-1:0]         a1_s;
    logic signed [ACC1_W-1:0]      n_acc1;
    logic signed [ACC1_W-1:0]      r_acc1;
    logic [T_WIDTH-1:0]            r_a2;
    logic signed [C1_W-1:0]        r_c1_2;
    logic signed [COORD_WIDTH-1:0] r_p0_2;

    assign a1_s   = {1'b0, r_a1};
    assign n_acc1 = (r_cf1.c3 * a1_s) + (ACC1_W'(r_cf1.c2) <<< T_WIDTH);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_acc1 <= n_acc1;
            r_a2   <= r_a1;
            r_c1_2 <= r_cf1.c1;
            r_p0_2 <= r_cf1.p0;
        end
    end

    // Stage 3: acc1*t as two partial products
    logic signed [A_W-1:0]         a2_s;
    logic signed [LO1_W:0]         lo1_s;
    logic signed [HI1_W-1:0]       hi1_s;
    logic signed [LO1_W+A_W:0]     n_pl3;
    logic signed [HI1_W+A_W-1:0]   n_ph3;
    logic signed [LO1_W+A_W:0]     r_pl3;
    logic signed [HI1_W+A_W-1:0]   r_ph3;
    logic [T_WIDTH-1:0]            r_a3;
    logic signed [C1_W-1:0]        r_c1_3;
    logic signed [COORD_WIDTH-1:0] r_p0_3;

    assign a2_s  = {1'b0, r_a2};
    assign lo1_s = {1'b0, r_acc1[LO1_W-1:0]};
    assign hi1_s = r_acc1[ACC1_W-1:LO1_W];
    assign n_pl3 = lo1_s * a2_s;
    assign n_ph3 = hi1_s * a2_s;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_pl3  <= n_pl3;
            r_ph3  <= n_ph3;
            r_a3   <= r_a2;
            r_c1_3 <= r_c1_2;
            r_p0_3 <= r_p0_2;
        end
    end

    // Stage 4: acc2 = acc1*t + c1 << 2T
    logic signed [ACC2_W-1:0]      n_acc2;
    logic signed [ACC2_W-1:0]      r_acc2;
    logic [T_WIDTH-1:0]            r_a4;
    logic signed [COORD_WIDTH-1:0] r_p0_4;

    assign n_acc2 = (ACC2_W'(r_ph3) <<< LO1_W) + ACC2_W'(r_pl3)
                  + (ACC2_W'(r_c1_3) <<< (2 * T_WIDTH));

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r_acc2 <= n_acc2;
            r_a4   <= r_a3;
            r_p0_4 <= r_p0_3;
        end
    end

    // Stage 5: acc2*t as two partial products
    logic signed [A_W-1:0]         a4_s;
    logic signed [LO2_W:0]         lo2_s;
    logic signed [HI2_W-1:0]       hi2_s;
    logic signed [LO2_W+A_W:0]     n_ql5;
    logic signed [HI2_W+A_W-1:0]   n_qh5;
    logic signed [LO2_W+A_W:0]     r_ql5;
    logic signed [HI2_W+A_W-1:0]   r_qh5;
    logic signed [COORD_WIDTH-1:0] r_p0_5;

    assign a4_s  = {1'b0, r_a4};
    assign lo2_s = {1'b0, r_acc2[LO2_W-1:0]};
    assign hi2_s = r_acc2[ACC2_W-1:LO2_W];
    assign n_ql5 = lo2_s * a4_s;
    assign n_qh5 = hi2_s * a4_s;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            r_ql5  <= n_ql5;
            r_qh5  <= n_qh5;
            r_p0_5 <= r_p0_4;
        end
    end

    // Stage 6: add p0 << 3T and the half step, keep the integer part
    logic [ACC3_W-1:0]             n_acc3;
    logic signed [COORD_WIDTH-1:0] r_res;

    assign n_acc3 = (ACC3_W'(r_qh5) <<< LO2_W) + ACC3_W'(r_ql5)
                  + (ACC3_W'(r_p0_5) <<< RND_POS) + RND_HALF;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[5]) begin
            r_res <= n_acc3[RND_POS +: COORD_WIDTH];
        end
    end

    assign o_res = r_res;

endmodule
